/* rtl/oml_pkg.sv */
// shared types, constants and codes for the ordered member list
package oml_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [31:0] t_member;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;

    // input opcodes
    localparam logic [1:0] OP_JOIN  = 2'd0;
    localparam logic [1:0] OP_LEAVE = 2'd1;
    localparam logic [1:0] OP_LIST  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_JOINED   = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_LISTED   = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    // what every cell of the ring does in a cycle
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_ROTATE = 2'd2,
        CMD_DROP   = 2'd3
    } t_cell_cmd;

    // control broadcast from the sequencer to all cells
    typedef struct packed {
        t_cell_cmd cmd;
        t_idx      sel;
        t_member   load;
    } t_cell_ctl;

endpackage

/* rtl/oml_if.sv */
// valid/ready channel interfaces for requests and results
interface oml_in_if;
    import oml_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    t_member    member_id;

    modport source (output valid, output opcode, output member_id, input ready);
    modport sink (input valid, input opcode, input member_id, output ready);
endinterface

interface oml_out_if;
    import oml_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] status;
    t_member    member_value;
    logic       last_of_run;

    modport source (output valid, output status, output member_value, output last_of_run,
                    input ready);
    modport sink (input valid, input status, input member_value, input last_of_run,
                  output ready);
endinterface

/* rtl/oml_cell.sv */
// one ring cell: holds a single list entry, loads a value or takes its neighbor's
module oml_cell
    import oml_pkg::*;
(
    input  logic      i_clk,
    input  t_idx      i_index,
    input  t_cell_ctl i_ctl,
    input  t_member   i_next,
    input  t_member   i_head,
    output t_member   o_value
);

    t_member r_value;
    t_member n_value;

    // next value from the broadcast command
    always_comb begin
        n_value = r_value;
        unique case (i_ctl.cmd)
            CMD_LOAD: begin
                if (i_index == i_ctl.sel) begin
                    n_value = i_ctl.load;
                end
            end
            CMD_ROTATE: begin
                // the tail closes the ring back to the head
                n_value = (i_index == i_ctl.sel) ? i_head : i_next;
            end
            CMD_DROP: begin
                n_value = i_next;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* rtl/ordered_member_list.sv */
// Ordered member list: keeps up to CAPACITY member numbers oldest first.
// Requests arrive on i_in (opcode, member_id), results leave on o_out
// (status, member_value, last_of_run); a transfer happens when valid and
// ready are both high. Entries live in a ring of cells; every cell hands
// its value to the neighbor in front of it, and the head feeds the tail.
// Join: written straight into the cell at the tail, result registered in
//   the accepting cycle and valid in the next cycle.
// Leave: the ring turns once around its n entries, one step per cycle
//   after the accepting cycle, comparing the head; the first match is
//   dropped instead of turned. One result after the last step, which waits
//   for room in the output register; an empty list gives it without a walk.
// List: the ring turns once, the head going out as one result per cycle
//   while the receiver takes them, first result registered once S_LIST
//   follows acceptance, or a single empty result in the accepting cycle.
// Opcode 3 is taken and gives nothing.
// A request is taken only while the sequencer is idle and the output
// register is free or being drained in the same cycle. When the receiver
// stalls, the ring and the step counter stop until the result is taken.
// Reset empties the list and the output register; entry contents are not
// cleared and need no sweep.
module ordered_member_list
    import oml_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    oml_in_if.sink      i_in,
    oml_out_if.source   o_out
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LEAVE = 3'b010,
        S_LIST  = 3'b100
    } t_state;

    t_state     r_state, n_state;
    t_cnt       r_count, n_count;
    t_cnt       r_step, n_step;
    t_cnt       r_len, n_len;
    logic       r_found, n_found;
    t_member    r_id, n_id;
    logic       r_out_valid, n_out_valid;
    logic [2:0] r_status, n_status;
    t_member    r_value, n_value;
    logic       r_last, n_last;

    t_cell_ctl  w_ctl;
    t_member    w_cells [CAPACITY];
    t_cnt       w_count_m1;
    t_idx       w_tail_idx;
    logic       w_out_free;
    logic       w_in_fire;
    logic       w_last_step;
    logic       w_hit;

    // ring of cells
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        oml_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(j)),
            .i_ctl   (w_ctl),
            .i_next  (w_cells[(j + 1) % CAPACITY]),
            .i_head  (w_cells[0]),
            .o_value (w_cells[j])
        );
    end

    assign w_count_m1  = r_count - CNT_W'(1);
    assign w_tail_idx  = w_count_m1[IDX_W-1:0];
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_last_step = (r_step == r_len - CNT_W'(1));
    assign w_hit       = (w_cells[0] == r_id) && !r_found;

    // sequencer and result formation
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_len       = r_len;
        n_found     = r_found;
        n_id        = r_id;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_value     = r_value;
        n_last      = r_last;
        w_ctl.cmd   = CMD_HOLD;
        w_ctl.sel   = w_tail_idx;
        w_ctl.load  = i_in.member_id;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    unique case (i_in.opcode)
                        OP_JOIN: begin
                            n_out_valid = 1'b1;
                            n_value     = i_in.member_id;
                            n_last      = 1'b1;
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.cmd = CMD_LOAD;
                                w_ctl.sel = r_count[IDX_W-1:0];
                                n_count   = r_count + CNT_W'(1);
                                n_status  = ST_JOINED;
                            end
                        end
                        OP_LEAVE: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_NOTFOUND;
                                n_value     = i_in.member_id;
                                n_last      = 1'b1;
                            end else begin
                                n_id    = i_in.member_id;
                                n_step  = '0;
                                n_len   = r_count;
                                n_found = 1'b0;
                                n_state = S_LEAVE;
                            end
                        end
                        OP_LIST: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_EMPTY;
                                n_value     = '0;
                                n_last      = 1'b1;
                            end else begin
                                n_step  = '0;
                                n_len   = r_count;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEAVE: begin
                // the final step waits for room in the output register
                if (!w_last_step || w_out_free) begin
                    if (w_hit) begin
                        w_ctl.cmd = CMD_DROP;
                        n_count   = w_count_m1;
                        n_found   = 1'b1;
                    end else begin
                        w_ctl.cmd = CMD_ROTATE;
                    end
                    n_step = r_step + CNT_W'(1);
                    if (w_last_step) begin
                        n_out_valid = 1'b1;
                        n_status    = (w_hit || r_found) ? ST_REMOVED : ST_NOTFOUND;
                        n_value     = r_id;
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_LIST: begin
                // head goes out while the ring turns by one
                if (w_out_free) begin
                    w_ctl.cmd   = CMD_ROTATE;
                    n_out_valid = 1'b1;
                    n_status    = ST_LISTED;
                    n_value     = w_cells[0];
                    n_last      = w_last_step;
                    n_step      = r_step + CNT_W'(1);
                    if (w_last_step) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_len       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_len       <= n_len;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.member_value = r_value;
    assign o_out.last_of_run  = r_last;

    // fill level never passes the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a join on a list with room grows it by one
    a_join_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.opcode == OP_JOIN && r_count != CNT_W'(CAPACITY))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("join did not grow the list");

    // a leave walk never runs on an empty ring
    a_leave_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEAVE) |-> (r_count != '0))
        else $error("leave walk on empty list");

    // the walk stays within the entries it started with
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEAVE || r_state == S_LIST) |-> (r_step < r_len))
        else $error("walk step beyond list length");

    // a list run ends with its last flag
    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST && w_out_free && w_last_step) |=> (r_out_valid && r_last))
        else $error("list run ended without last flag");

endmodule
